// ===== hw/rtl/rc4_pkg.sv =====
// Shared types and constants for the RC4 keystream generator.
// No dependencies; used by rc4_perm_store, rc4_add3 and the top level.
`default_nettype none

package rc4_pkg;

    localparam int BYTE_W     = 8;
    localparam int IDX_W      = 8;
    localparam int CNT_W      = 7;
    localparam int STAT_W     = 2;
    localparam int PERM_DEPTH = 256;
    localparam int SEED_CNT_W = 9;

    // input kinds (tuser on the slave side)
    localparam logic KIND_SEED = 1'b0;
    localparam logic KIND_GEN  = 1'b1;

    // result status codes (tuser on the master side)
    localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_IGNORED  = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_UNSEEDED = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEED_RDJ,
        ST_SEED_WR_J,
        ST_SEED_WR_POS,
        ST_GEN_RDI,
        ST_GEN_RDJ,
        ST_GEN_WRI,
        ST_GEN_WRJ,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [BYTE_W-1:0] rnd;
        logic [STAT_W-1:0] status;
        logic              last;
    } t_result;

    // one cycle of permutation table access: one write and one read
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [BYTE_W-1:0] wdata;
        logic [IDX_W-1:0] raddr;
    } t_perm_req;

endpackage

`default_nettype wire

// ===== hw/rtl/rc4_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hw/rtl/rc4_perm_store.sv =====
// Permutation table: RAM plus per-entry valid bits so that an unwritten
// entry reads as its own index (identity after reset). Uses rc4_pkg, rc4_ram.
`default_nettype none

module rc4_perm_store (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire rc4_pkg::t_perm_req        i_req,
    output logic [rc4_pkg::BYTE_W-1:0]     o_rdata
);

    logic [rc4_pkg::PERM_DEPTH-1:0] r_vld;
    logic                           r_rd_vld;
    logic [rc4_pkg::IDX_W-1:0]      r_rd_addr;
    logic [rc4_pkg::BYTE_W-1:0]     w_ram_q;

    rc4_ram #(
        .WIDTH (rc4_pkg::BYTE_W),
        .DEPTH (rc4_pkg::PERM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_req.we),
        .i_waddr (i_req.waddr),
        .i_wdata (i_req.wdata),
        .i_raddr (i_req.raddr),
        .o_rdata (w_ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_req.we) begin
                r_vld[i_req.waddr] <= 1'b1;
            end
            r_rd_vld <= r_vld[i_req.raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_addr <= i_req.raddr;
    end

    // old-data read: a same-cycle write shows up one read later
    assign o_rdata = r_rd_vld ? w_ram_q : r_rd_addr;

endmodule

`default_nettype wire

// ===== hw/rtl/rc4_add3.sv =====
// Shared 8-bit index adder (modulo 256), three operands.
// Uses rc4_pkg for widths.
`default_nettype none

module rc4_add3 (
    input  wire logic [rc4_pkg::IDX_W-1:0] i_a,
    input  wire logic [rc4_pkg::IDX_W-1:0] i_b,
    input  wire logic [rc4_pkg::IDX_W-1:0] i_c,
    output logic      [rc4_pkg::IDX_W-1:0] o_sum
);

    assign o_sum = i_a + i_b + i_c;

endmodule

`default_nettype wire

// ===== hw/rtl/rc4_keystream_generator.sv =====
// RC4 keystream generator, top level.
// Uses rc4_pkg, rc4_perm_store (with rc4_ram) and rc4_add3.
`default_nettype none

// The block holds a 256-byte RC4 permutation in one RAM with a single read
// and a single write port; per-entry valid bits make it read as the identity
// right after reset, so there is no clearing pass. Feed 256 seed transfers
// (tuser = 0, seed byte in tdata[7:0]); each runs one key-schedule step and
// returns one result with status OK. After the 256th the generator is seeded;
// further seed transfers return status IGNORED and change nothing. A generate
// transfer (tuser = 1, count in tdata[14:8]) returns count keystream bytes
// (count 0 means 1, counts above MAX_BURST are clipped), tlast on the final
// one; before seeding it returns one result with status UNSEEDED. Only one
// input transfer is in work at a time: tready is high only while the
// sequencer is idle. A seed byte runs through the states SEED_RDJ,
// SEED_WR_J and SEED_WR_POS; an error result is made in IDLE as the
// transfer is taken; a generate request runs GEN_RDI, GEN_RDJ, GEN_WRI and
// GEN_WRJ once per keystream byte. This order is set by the permutation
// RAM: three dependent reads (s[i], s[j], s[a+b]) and two swap writes
// share its one read and one write port; the s[i] write overlaps the
// s[a+b] read and the s[j] write takes a state of its own. All index sums
// are made by one shared adder. A stalled output holds the sequencer.
module rc4_keystream_generator #(
    parameter int MAX_BURST = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [7:0] seed_byte, [14:8] count, [15] zero
    input  wire logic        s_axis_tuser,   // [0] kind
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] random_byte
    output logic [1:0]       m_axis_tuser,   // [1:0] status
    output logic             m_axis_tlast
);

    localparam logic [rc4_pkg::CNT_W-1:0] BURST_MAX = rc4_pkg::CNT_W'(MAX_BURST);

    // sequencer and index state
    rc4_pkg::t_state                    r_state, n_state;
    logic [rc4_pkg::SEED_CNT_W-1:0]     r_pos;      // seed bytes taken; bit 8 = seeded
    logic [rc4_pkg::IDX_W-1:0]          r_i;
    logic [rc4_pkg::IDX_W-1:0]          r_j;
    logic [rc4_pkg::BYTE_W-1:0]         r_a;        // s[i] (or s[pos] when seeding)
    logic [rc4_pkg::BYTE_W-1:0]         r_b;        // s[j] before the swap
    logic [rc4_pkg::IDX_W-1:0]          r_k;        // a + b, keystream index
    logic [rc4_pkg::BYTE_W-1:0]         r_seed;
    logic [rc4_pkg::CNT_W-1:0]          r_cnt;      // bytes still owed
    // pending result when the output register is busy
    rc4_pkg::t_result                   r_pend;
    rc4_pkg::t_state                    r_after;
    // output register
    logic                               r_m_valid;
    rc4_pkg::t_result                   r_m_res;

    logic                               w_in_xfer;
    logic                               w_kind;
    logic [rc4_pkg::BYTE_W-1:0]         w_seed_in;
    logic [rc4_pkg::CNT_W-1:0]          w_count_in;
    logic [rc4_pkg::CNT_W-1:0]          w_count_clip;
    logic                               w_seeded;
    logic                               w_slot_free;

    rc4_pkg::t_perm_req                 w_req;
    logic [rc4_pkg::BYTE_W-1:0]         w_rdata;
    logic [rc4_pkg::IDX_W-1:0]          w_add_a, w_add_b, w_add_c, w_sum;
    logic [rc4_pkg::BYTE_W-1:0]         w_key;
    logic                               w_res_valid;
    rc4_pkg::t_result                   w_res;
    rc4_pkg::t_state                    w_after;

    assign w_kind      = s_axis_tuser;
    assign w_seed_in   = s_axis_tdata[7:0];
    assign w_count_in  = s_axis_tdata[14:8];
    assign w_seeded    = r_pos[8];
    assign w_in_xfer   = s_axis_tvalid && s_axis_tready;
    assign w_slot_free = !r_m_valid || m_axis_tready;

    always_comb begin
        if (w_count_in == '0) begin
            w_count_clip = rc4_pkg::CNT_W'(1);
        end else if (w_count_in > BURST_MAX) begin
            w_count_clip = BURST_MAX;
        end else begin
            w_count_clip = w_count_in;
        end
    end

    rc4_perm_store u_perm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rdata (w_rdata)
    );

    rc4_add3 u_add (
        .i_a   (w_add_a),
        .i_b   (w_add_b),
        .i_c   (w_add_c),
        .o_sum (w_sum)
    );

    // keystream byte after the swap: s[j] now holds a, s[i] holds b
    always_comb begin
        if (r_k == r_j) begin
            w_key = r_a;
        end else if (r_k == r_i) begin
            w_key = r_b;
        end else begin
            w_key = w_rdata;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rc4_pkg::ST_IDLE: begin
                if (w_in_xfer) begin
                    if (w_kind == rc4_pkg::KIND_SEED && !w_seeded) begin
                        n_state = rc4_pkg::ST_SEED_RDJ;
                    end else if (w_kind == rc4_pkg::KIND_GEN && w_seeded) begin
                        n_state = rc4_pkg::ST_GEN_RDI;
                    end else if (!w_slot_free) begin
                        n_state = rc4_pkg::ST_EMIT;
                    end
                end
            end
            rc4_pkg::ST_SEED_RDJ:  n_state = rc4_pkg::ST_SEED_WR_J;
            rc4_pkg::ST_SEED_WR_J: n_state = rc4_pkg::ST_SEED_WR_POS;
            rc4_pkg::ST_SEED_WR_POS: begin
                n_state = w_slot_free ? w_after : rc4_pkg::ST_EMIT;
            end
            rc4_pkg::ST_GEN_RDI: n_state = rc4_pkg::ST_GEN_RDJ;
            rc4_pkg::ST_GEN_RDJ: n_state = rc4_pkg::ST_GEN_WRI;
            rc4_pkg::ST_GEN_WRI: n_state = rc4_pkg::ST_GEN_WRJ;
            rc4_pkg::ST_GEN_WRJ: begin
                n_state = w_slot_free ? w_after : rc4_pkg::ST_EMIT;
            end
            rc4_pkg::ST_EMIT: begin
                if (w_slot_free) begin
                    n_state = r_after;
                end
            end
            default: n_state = rc4_pkg::ST_IDLE;
        endcase
    end

    // datapath control: adder operands, table access, result
    always_comb begin
        w_add_a     = '0;
        w_add_b     = '0;
        w_add_c     = '0;
        w_req       = '0;
        w_res_valid = 1'b0;
        w_res       = '0;
        w_after     = rc4_pkg::ST_IDLE;
        case (r_state)
            rc4_pkg::ST_IDLE: begin
                w_req.raddr = r_pos[7:0];    // s[pos] ready for a seed step
                if (w_in_xfer) begin
                    if (w_kind == rc4_pkg::KIND_SEED && w_seeded) begin
                        w_res_valid = 1'b1;
                        w_res       = '{rnd: '0, status: rc4_pkg::STATUS_IGNORED, last: 1'b1};
                    end else if (w_kind == rc4_pkg::KIND_GEN && !w_seeded) begin
                        w_res_valid = 1'b1;
                        w_res       = '{rnd: '0, status: rc4_pkg::STATUS_UNSEEDED, last: 1'b1};
                    end
                end
            end
            rc4_pkg::ST_SEED_RDJ: begin
                // j += s[pos] + seed, then fetch s[j]
                w_add_a     = r_j;
                w_add_b     = w_rdata;
                w_add_c     = r_seed;
                w_req.raddr = w_sum;
            end
            rc4_pkg::ST_SEED_WR_J: begin
                w_req.we    = 1'b1;
                w_req.waddr = r_j;
                w_req.wdata = r_a;
            end
            rc4_pkg::ST_SEED_WR_POS: begin
                w_req.we    = 1'b1;
                w_req.waddr = r_pos[7:0];
                w_req.wdata = r_b;
                w_res_valid = 1'b1;
                w_res       = '{rnd: '0, status: rc4_pkg::STATUS_OK, last: 1'b1};
            end
            rc4_pkg::ST_GEN_RDI: begin
                w_add_a     = r_i;
                w_add_b     = rc4_pkg::IDX_W'(1);
                w_req.raddr = w_sum;
            end
            rc4_pkg::ST_GEN_RDJ: begin
                w_add_a     = r_j;
                w_add_b     = w_rdata;
                w_req.raddr = w_sum;
            end
            rc4_pkg::ST_GEN_WRI: begin
                // s[i] = b; start the read of s[a + b] (old data, patched later)
                w_add_a     = r_a;
                w_add_b     = w_rdata;
                w_req.we    = 1'b1;
                w_req.waddr = r_i;
                w_req.wdata = w_rdata;
                w_req.raddr = w_sum;
            end
            rc4_pkg::ST_GEN_WRJ: begin
                w_req.we    = 1'b1;
                w_req.waddr = r_j;
                w_req.wdata = r_a;
                w_res_valid = 1'b1;
                w_res.rnd   = w_key;
                w_res.status = rc4_pkg::STATUS_OK;
                w_res.last  = (r_cnt == rc4_pkg::CNT_W'(1));
                w_after     = w_res.last ? rc4_pkg::ST_IDLE : rc4_pkg::ST_GEN_RDI;
            end
            rc4_pkg::ST_EMIT: begin
                w_res_valid = 1'b1;
                w_res       = r_pend;
            end
            default: begin
                w_res_valid = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rc4_pkg::ST_IDLE;
            r_pos     <= '0;
            r_i       <= '0;
            r_j       <= '0;
            r_cnt     <= '0;
            r_m_valid <= 1'b0;
            r_after   <= rc4_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
            if (w_res_valid && w_slot_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            if (w_res_valid && !w_slot_free && r_state != rc4_pkg::ST_EMIT) begin
                r_after <= w_after;
            end
            case (r_state)
                rc4_pkg::ST_IDLE: begin
                    if (w_in_xfer) begin
                        r_cnt <= w_count_clip;
                    end
                end
                rc4_pkg::ST_SEED_RDJ: r_j <= w_sum;
                rc4_pkg::ST_SEED_WR_POS: begin
                    r_pos <= r_pos + 1'b1;
                    if (r_pos[7:0] == 8'hFF) begin
                        // schedule done: generation starts at i = j = 0
                        r_i <= '0;
                        r_j <= '0;
                    end
                end
                rc4_pkg::ST_GEN_RDI: r_i <= w_sum;
                rc4_pkg::ST_GEN_RDJ: r_j <= w_sum;
                rc4_pkg::ST_GEN_WRJ: r_cnt <= r_cnt - 1'b1;
                default: begin
                    r_cnt <= r_cnt;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_slot_free) begin
            r_m_res <= w_res;
        end
        if (w_res_valid && !w_slot_free && r_state != rc4_pkg::ST_EMIT) begin
            r_pend <= w_res;
        end
        case (r_state)
            rc4_pkg::ST_IDLE: r_seed <= w_seed_in;
            rc4_pkg::ST_SEED_RDJ: r_a <= w_rdata;
            rc4_pkg::ST_SEED_WR_J: r_b <= w_rdata;
            rc4_pkg::ST_GEN_RDJ: r_a <= w_rdata;
            rc4_pkg::ST_GEN_WRI: begin
                r_b <= w_rdata;
                r_k <= w_sum;
            end
            default: begin
                r_a <= r_a;
            end
        endcase
    end

    assign s_axis_tready = (r_state == rc4_pkg::ST_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_res.rnd;
    assign m_axis_tuser  = r_m_res.status;
    assign m_axis_tlast  = r_m_res.last;

`ifndef SYNTHESIS
    // once seeded, the generator never falls back
    a_seeded_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(r_pos[8]) |-> r_pos[8])
        else $error("seeded flag dropped");

    // the seed counter stops at exactly 256
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos[8] |-> (r_pos[7:0] == '0))
        else $error("seed counter beyond 256");

    // a burst byte is only started while bytes are still owed
    a_cnt_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rc4_pkg::ST_GEN_RDI) |-> (r_cnt != '0))
        else $error("keystream byte started with zero count");

    // a late seed byte is answered with IGNORED or parked for output
    a_seed_ignored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer && (w_kind == rc4_pkg::KIND_SEED) && r_pos[8] |=>
        (r_state == rc4_pkg::ST_EMIT) ||
        (m_axis_tvalid && (m_axis_tuser == rc4_pkg::STATUS_IGNORED)))
        else $error("late seed byte not reported as ignored");
`endif

endmodule

`default_nettype wire
